FILE: sv/i8211_pkg.sv
// shared types, constants and helpers of the iso 8211 record parser
// no dependencies; used by i8211_step, i8211_out_reg and the top level
package i8211_pkg;

    // tag characters that fit the entry tag output
    localparam int TAG_BYTES  = 4;
    // width of the field and unit counters before the 8-bit output cap
    localparam int INDEX_BITS = 8;
    localparam int IDX_MAX    = (INDEX_BITS < 8) ? ((1 << INDEX_BITS) - 1) : 255;

    localparam logic [7:0] FIELD_SEP = 8'h1E;
    localparam logic [7:0] UNIT_SEP  = 8'h1F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // leader byte offsets
    localparam logic [16:0] LDR_LEN_END   = 17'd5;
    localparam logic [16:0] LDR_BASE_LO   = 17'd12;
    localparam logic [16:0] LDR_BASE_END  = 17'd17;
    localparam logic [16:0] LDR_LEN_SIZE  = 17'd20;
    localparam logic [16:0] LDR_POS_SIZE  = 17'd21;
    localparam logic [16:0] LDR_TAG_SIZE  = 17'd23;
    localparam logic [16:0] LEADER_BYTES  = 17'd24;

    // parse phases
    localparam logic [1:0] PH_LEADER = 2'd0;
    localparam logic [1:0] PH_DIR    = 2'd1;
    localparam logic [1:0] PH_GAP    = 2'd2;
    localparam logic [1:0] PH_FIELD  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_DIR_END = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;

    typedef struct packed {
        logic [16:0] byte_offset;
        logic [16:0] rec_len;
        logic [16:0] base_addr;
        logic [3:0]  len_size;
        logic [3:0]  pos_size;
        logic [3:0]  tag_size;
        logic [4:0]  entry_offset;
        logic [31:0] tag_acc;
        logic [29:0] len_acc;
        logic [29:0] pos_acc;
        logic [1:0]  phase;
        logic [7:0]  field_count;
        logic [7:0]  unit_count;
        logic        error_seen;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] entry_tag;
        logic [29:0] entry_length;
        logic [29:0] entry_position;
        logic [16:0] record_length;
        logic [16:0] base_address;
        logic [7:0]  data_byte;
        logic [7:0]  field_index;
        logic [7:0]  unit_index;
        logic        format_error;
        logic        last_of_record;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // non-digits count as zero
    function automatic logic [3:0] digit_val(input logic [7:0] b);
        logic [7:0] d;
        d = b - CHAR_ZERO;
        return is_digit(b) ? d[3:0] : 4'd0;
    endfunction

    // acc * 10 + d
    function automatic logic [29:0] dec_acc(input logic [29:0] acc, input logic [3:0] d);
        return (acc << 3) + (acc << 1) + {26'd0, d};
    endfunction

endpackage

FILE: sv/iso8211_record_directory_parser_top.sv
// iso 8211 record leader and directory parser, top level
// depends on i8211_pkg, i8211_step and i8211_out_reg
//
// takes a record stream one byte per word and returns at most one word per byte. the 24-byte
// leader is decoded silently (record length, base address, subfield sizes); each directory
// entry then gives a kind 0 word with its tag, length and position, the directory terminator
// gives a kind 1 word, bytes up to the base address are dropped, and every field-area byte
// gives a kind 2 word with its field and unit index. tlast marks the word of a record's final
// byte, if that byte gives one, after which the parser starts afresh. throughput is one byte per
// clock: the whole step is a digit accumulate and an offset compare between the parse state and
// the result register, so a result appears in the cycle after its byte and s_tready only drops
// while a held result is not taken.
module iso8211_record_directory_parser_top (
    input  logic         aclk,
    input  logic         aresetn,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // [31:0] entry_tag, [61:32] entry_length,
                                    // [91:62] entry_position, [108:92] record_length,
                                    // [125:109] base_address, [133:126] data_byte,
                                    // [141:134] field_index, [149:142] unit_index,
                                    // [150] format_error, [151] zero
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast    // last_of_record
);

    i8211_pkg::parse_state_t state_reg;
    i8211_pkg::parse_state_t state_next;
    i8211_pkg::result_t      step_res;
    i8211_pkg::result_t      out_res;
    logic                    step_emit;
    logic                    accept;
    logic                    out_full;

    // a new byte may enter whenever the result slot is empty or being emptied
    assign s_tready = !out_full || m_tready;
    assign accept   = s_tvalid && s_tready;

    i8211_step u_step (
        .cur     (state_reg),
        .in_byte (s_tdata),
        .nxt     (state_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    // parse state advances only on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    i8211_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && step_emit),
        .load_data (step_res),
        .take      (m_tready),
        .full      (out_full),
        .data      (out_res)
    );

    assign m_tvalid = out_full;
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.last_of_record;
    assign m_tdata  = {1'b0,
                       out_res.format_error,
                       out_res.unit_index,
                       out_res.field_index,
                       out_res.data_byte,
                       out_res.base_address,
                       out_res.record_length,
                       out_res.entry_position,
                       out_res.entry_length,
                       out_res.entry_tag};

endmodule

FILE: sv/i8211_step.sv
// next-state and result logic for one record byte
// depends on i8211_pkg
module i8211_step (
    input  i8211_pkg::parse_state_t cur,
    input  logic [7:0]              in_byte,
    output i8211_pkg::parse_state_t nxt,
    output logic                    emit,
    output i8211_pkg::result_t      res
);

    always_comb begin
        logic [3:0]  d;
        logic        bad;
        logic        err;
        logic        leader_done;
        logic        last;
        logic [1:0]  ph;
        logic [4:0]  total;
        logic [4:0]  eo;
        logic [17:0] off_inc;

        d           = i8211_pkg::digit_val(in_byte);
        bad         = !i8211_pkg::is_digit(in_byte);
        nxt         = cur;
        err         = cur.error_seen;
        emit        = 1'b0;
        res         = '0;
        ph          = cur.phase;
        total       = {1'b0, cur.tag_size} + {1'b0, cur.len_size} + {1'b0, cur.pos_size};
        eo          = cur.entry_offset;
        leader_done = (cur.phase != i8211_pkg::PH_LEADER) ||
                      (cur.byte_offset == i8211_pkg::LDR_TAG_SIZE);

        if (cur.phase == i8211_pkg::PH_LEADER) begin
            if (cur.byte_offset < i8211_pkg::LDR_LEN_END) begin
                nxt.rec_len = 17'(i8211_pkg::dec_acc({13'd0, cur.rec_len}, d));
                err = err | bad;
            end else if (cur.byte_offset >= i8211_pkg::LDR_BASE_LO &&
                         cur.byte_offset < i8211_pkg::LDR_BASE_END) begin
                nxt.base_addr = 17'(i8211_pkg::dec_acc({13'd0, cur.base_addr}, d));
                err = err | bad;
            end else if (cur.byte_offset == i8211_pkg::LDR_LEN_SIZE) begin
                nxt.len_size = d;
                err = err | bad;
            end else if (cur.byte_offset == i8211_pkg::LDR_POS_SIZE) begin
                nxt.pos_size = d;
                err = err | bad;
            end else if (cur.byte_offset == i8211_pkg::LDR_TAG_SIZE) begin
                nxt.tag_size = d;
                err = err | bad;
                if ({28'd0, d} > 32'(i8211_pkg::TAG_BYTES)) begin
                    err = 1'b1;
                end
                if (cur.rec_len < i8211_pkg::LEADER_BYTES ||
                    cur.base_addr < i8211_pkg::LEADER_BYTES) begin
                    err = 1'b1;
                end
                nxt.phase        = i8211_pkg::PH_DIR;
                nxt.entry_offset = '0;
            end
        end else begin
            // directory overrun or gap end: switch to the field area
            if ((ph == i8211_pkg::PH_DIR || ph == i8211_pkg::PH_GAP) &&
                cur.byte_offset >= cur.base_addr) begin
                if (ph == i8211_pkg::PH_DIR) begin
                    err = 1'b1;
                end
                ph = i8211_pkg::PH_FIELD;
            end
            nxt.phase = ph;
            if (ph == i8211_pkg::PH_DIR) begin
                if (eo == 5'd0 && in_byte == i8211_pkg::FIELD_SEP) begin
                    emit      = 1'b1;
                    res.kind  = i8211_pkg::KIND_DIR_END;
                    nxt.phase = i8211_pkg::PH_GAP;
                end else if (total == 5'd0) begin
                    err = 1'b1;
                end else begin
                    if (eo < {1'b0, cur.tag_size}) begin
                        nxt.tag_acc = {cur.tag_acc[23:0], in_byte};
                    end else if (eo < {1'b0, cur.tag_size} + {1'b0, cur.len_size}) begin
                        nxt.len_acc = i8211_pkg::dec_acc(cur.len_acc, d);
                        err = err | bad;
                    end else begin
                        nxt.pos_acc = i8211_pkg::dec_acc(cur.pos_acc, d);
                        err = err | bad;
                    end
                    eo = eo + 5'd1;
                    if (eo >= total) begin
                        emit               = 1'b1;
                        res.kind           = i8211_pkg::KIND_ENTRY;
                        res.entry_tag      = nxt.tag_acc;
                        res.entry_length   = nxt.len_acc;
                        res.entry_position = nxt.pos_acc;
                        nxt.tag_acc        = '0;
                        nxt.len_acc        = '0;
                        nxt.pos_acc        = '0;
                        eo                 = '0;
                    end
                    nxt.entry_offset = eo;
                end
            end else if (ph == i8211_pkg::PH_FIELD) begin
                emit            = 1'b1;
                res.kind        = i8211_pkg::KIND_DATA;
                res.data_byte   = in_byte;
                res.field_index = cur.field_count;
                res.unit_index  = cur.unit_count;
                if (in_byte == i8211_pkg::FIELD_SEP) begin
                    if (cur.field_count < 8'(i8211_pkg::IDX_MAX)) begin
                        nxt.field_count = cur.field_count + 8'd1;
                    end
                    nxt.unit_count = '0;
                end else if (in_byte == i8211_pkg::UNIT_SEP) begin
                    if (cur.unit_count < 8'(i8211_pkg::IDX_MAX)) begin
                        nxt.unit_count = cur.unit_count + 8'd1;
                    end
                end
            end
        end

        off_inc = {1'b0, cur.byte_offset} + 18'd1;
        last    = leader_done && (off_inc >= {1'b0, nxt.rec_len});

        res.record_length  = nxt.rec_len;
        res.base_address   = nxt.base_addr;
        res.format_error   = err;
        res.last_of_record = last;

        nxt.error_seen = err;
        if (last) begin
            nxt = '0;
        end else begin
            nxt.byte_offset = off_inc[16:0];
        end
    end

endmodule

FILE: sv/i8211_out_reg.sv
// result register between the parser and the master-side stream
// depends on i8211_pkg
module i8211_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  i8211_pkg::result_t load_data,
    input  logic               take,
    output logic               full,
    output i8211_pkg::result_t data
);

    logic               valid_reg;
    logic               valid_next;
    i8211_pkg::result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign full = valid_reg;
    assign data = data_reg;

endmodule

FILE: tb/tb_iso8211_record_directory_parser_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the iso 8211 record leader and directory parser
// depends on i8211_pkg and iso8211_record_directory_parser_top; builds record streams,
// predicts every result word in place and compares it against the master side
module tb_iso8211_record_directory_parser_top;

    localparam int CYCLE_LIMIT = 1000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    iso8211_record_directory_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // parser state as the predictor sees it
    logic [16:0] p_offset;
    logic [16:0] p_rec_len;
    logic [16:0] p_base;
    logic [3:0]  p_lsz;
    logic [3:0]  p_psz;
    logic [3:0]  p_tsz;
    logic [4:0]  p_entry_pos;
    logic [31:0] p_tag;
    logic [29:0] p_len;
    logic [29:0] p_pos;
    logic [1:0]  p_phase;
    logic [7:0]  p_fields;
    logic [7:0]  p_units;
    logic        p_err;

    i8211_pkg::result_t expected_words[$];   // predicted words not yet seen on the master side
    logic [7:0]  dir_bytes[$];        // directory of the record under construction
    logic [7:0]  area_bytes[$];       // field area of the record under construction
    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    bit          idle_on;             // random gaps and stalls allowed

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit, far above the slowest correct run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        p_offset    = '0;
        p_rec_len   = '0;
        p_base      = '0;
        p_lsz       = '0;
        p_psz       = '0;
        p_tsz       = '0;
        p_entry_pos = '0;
        p_tag       = '0;
        p_len       = '0;
        p_pos       = '0;
        p_phase     = i8211_pkg::PH_LEADER;
        p_fields    = '0;
        p_units     = '0;
        p_err       = 1'b0;
    endfunction

    // advance the parser by one accepted byte, queue the word it gives if any
    function automatic void parse_byte(input logic [7:0] b);
        i8211_pkg::result_t r;
        logic        emit;
        logic        leader_done;
        logic        last;
        logic        nondig;
        logic [3:0]  dig;
        logic [16:0] off;
        logic [4:0]  eo;
        logic [4:0]  total;

        r      = '0;
        emit   = 1'b0;
        off    = p_offset;
        nondig = (b < i8211_pkg::CHAR_ZERO) || (b > i8211_pkg::CHAR_NINE);
        dig    = nondig ? 4'd0 : 4'(b - i8211_pkg::CHAR_ZERO);
        leader_done = (p_phase != i8211_pkg::PH_LEADER) || (off == i8211_pkg::LDR_TAG_SIZE);

        if (p_phase == i8211_pkg::PH_LEADER) begin
            if (off < i8211_pkg::LDR_LEN_END) begin
                p_rec_len = 17'(p_rec_len * 10 + dig);
                p_err |= nondig;
            end else if (off >= i8211_pkg::LDR_BASE_LO && off < i8211_pkg::LDR_BASE_END) begin
                p_base = 17'(p_base * 10 + dig);
                p_err |= nondig;
            end else if (off == i8211_pkg::LDR_LEN_SIZE) begin
                p_lsz = dig;
                p_err |= nondig;
            end else if (off == i8211_pkg::LDR_POS_SIZE) begin
                p_psz = dig;
                p_err |= nondig;
            end else if (off == i8211_pkg::LDR_TAG_SIZE) begin
                p_tsz = dig;
                p_err |= nondig;
                if (dig > i8211_pkg::TAG_BYTES) p_err = 1'b1;
                if (p_rec_len < i8211_pkg::LEADER_BYTES || p_base < i8211_pkg::LEADER_BYTES)
                    p_err = 1'b1;
                p_phase     = i8211_pkg::PH_DIR;
                p_entry_pos = '0;
            end
        end else begin
            // reaching the base address forces the field area
            if ((p_phase == i8211_pkg::PH_DIR || p_phase == i8211_pkg::PH_GAP) &&
                off >= p_base) begin
                if (p_phase == i8211_pkg::PH_DIR) p_err = 1'b1;
                p_phase = i8211_pkg::PH_FIELD;
            end
            if (p_phase == i8211_pkg::PH_DIR) begin
                total = 5'(p_tsz) + 5'(p_lsz) + 5'(p_psz);
                eo    = p_entry_pos;
                if (eo == 0 && b == i8211_pkg::FIELD_SEP) begin
                    emit    = 1'b1;
                    r.kind  = i8211_pkg::KIND_DIR_END;
                    p_phase = i8211_pkg::PH_GAP;
                end else if (total == 0) begin
                    p_err = 1'b1;
                end else begin
                    if (eo < 5'(p_tsz)) begin
                        p_tag = {p_tag[23:0], b};
                    end else if (eo < 5'(p_tsz) + 5'(p_lsz)) begin
                        p_len = 30'(p_len * 10 + dig);
                        p_err |= nondig;
                    end else begin
                        p_pos = 30'(p_pos * 10 + dig);
                        p_err |= nondig;
                    end
                    eo++;
                    if (eo >= total) begin
                        emit             = 1'b1;
                        r.kind           = i8211_pkg::KIND_ENTRY;
                        r.entry_tag      = p_tag;
                        r.entry_length   = p_len;
                        r.entry_position = p_pos;
                        p_tag = '0;
                        p_len = '0;
                        p_pos = '0;
                        eo    = '0;
                    end
                    p_entry_pos = eo;
                end
            end else if (p_phase == i8211_pkg::PH_FIELD) begin
                emit          = 1'b1;
                r.kind        = i8211_pkg::KIND_DATA;
                r.data_byte   = b;
                r.field_index = p_fields;
                r.unit_index  = p_units;
                if (b == i8211_pkg::FIELD_SEP) begin
                    if (p_fields < i8211_pkg::IDX_MAX) p_fields++;
                    p_units = '0;
                end else if (b == i8211_pkg::UNIT_SEP) begin
                    if (p_units < i8211_pkg::IDX_MAX) p_units++;
                end
            end
        end

        last = leader_done && (off + 1 >= p_rec_len);
        if (emit) begin
            r.record_length  = p_rec_len;
            r.base_address   = p_base;
            r.format_error   = p_err;
            r.last_of_record = last;
            expected_words.push_back(r);
        end
        if (last) clear_parser();
        else p_offset = 17'(off + 1);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_word();
        i8211_pkg::result_t want;
        if (expected_words.size() == 0) begin
            $error("kind: expected no word, got 0x%0h", m_tuser);
            error_count++;
        end else begin
            want = expected_words.pop_front();
            compare_field("kind",           64'(want.kind),           64'(m_tuser));
            compare_field("entry_tag",      64'(want.entry_tag),      64'(m_tdata[31:0]));
            compare_field("entry_length",   64'(want.entry_length),   64'(m_tdata[61:32]));
            compare_field("entry_position", 64'(want.entry_position), 64'(m_tdata[91:62]));
            compare_field("record_length",  64'(want.record_length),  64'(m_tdata[108:92]));
            compare_field("base_address",   64'(want.base_address),   64'(m_tdata[125:109]));
            compare_field("data_byte",      64'(want.data_byte),      64'(m_tdata[133:126]));
            compare_field("field_index",    64'(want.field_index),    64'(m_tdata[141:134]));
            compare_field("unit_index",     64'(want.unit_index),     64'(m_tdata[149:142]));
            compare_field("format_error",   64'(want.format_error),   64'(m_tdata[150]));
            compare_field("tdata_pad",      64'd0,                    64'(m_tdata[151]));
            compare_field("last_of_record", 64'(want.last_of_record), 64'(m_tlast));
        end
    endfunction

    // both handshakes are seen with their pre-edge values; prediction comes first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_byte(s_tdata);
            if (m_tvalid && m_tready) check_word();
        end
    end

    // result side: ready, with random stall bursts while idling is on
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // send one byte word, starting and ending at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned hold;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (hold) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // decimal digit character of v at the given power of ten
    function automatic logic [7:0] dec_char(input int unsigned v, input int unsigned place);
        return i8211_pkg::CHAR_ZERO + 8'((v / (10 ** place)) % 10);
    endfunction

    // tag characters are the low tsz bytes of tag, first character highest
    task automatic add_entry(input logic [71:0] tag, input int unsigned tsz,
                             input int unsigned len, input int unsigned lsz,
                             input int unsigned pos, input int unsigned psz);
        for (int i = int'(tsz) - 1; i >= 0; i--) dir_bytes.push_back(tag[8*i +: 8]);
        for (int i = int'(lsz) - 1; i >= 0; i--) dir_bytes.push_back(dec_char(len, i));
        for (int i = int'(psz) - 1; i >= 0; i--) dir_bytes.push_back(dec_char(pos, i));
    endtask

    // wrap the built directory and field area in a leader and send the record;
    // base and length follow from the layout unless overridden (>= 0), and
    // spoil_at puts a non-digit on a leader '0' (-2 picks one at random)
    task automatic ship_record(input int lsz, input int psz, input int tsz, input int gap_len,
                               input int base_ovr, input int rlen_ovr, input int spoil_at);
        logic [7:0]  leader[24];
        logic [7:0]  bad;
        int unsigned base;
        int unsigned rlen;
        int unsigned first;
        int unsigned slot;
        int unsigned at;

        base = (base_ovr >= 0) ? base_ovr : 24 + dir_bytes.size() + gap_len;
        rlen = (rlen_ovr >= 0) ? rlen_ovr : 24 + dir_bytes.size() + gap_len + area_bytes.size();
        for (int i = 0; i < 24; i++) leader[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 5; i++) begin
            leader[i]      = dec_char(rlen, 4 - i);
            leader[12 + i] = dec_char(base, 4 - i);
        end
        leader[20] = i8211_pkg::CHAR_ZERO + 8'(lsz);
        leader[21] = i8211_pkg::CHAR_ZERO + 8'(psz);
        leader[23] = i8211_pkg::CHAR_ZERO + 8'(tsz);

        // a non-digit in place of a zero keeps the record layout intact
        if (spoil_at == -2) begin
            first = $urandom_range(0, 12);
            for (int k = 0; k < 13; k++) begin
                slot = (first + k) % 13;
                at = (slot < 5) ? slot : (slot < 10) ? slot + 7 :
                     (slot == 10) ? 20 : (slot == 11) ? 21 : 23;
                if (leader[at] == i8211_pkg::CHAR_ZERO) begin
                    spoil_at = at;
                    break;
                end
            end
        end
        if (spoil_at >= 0) begin
            bad = 8'($urandom_range(0, 245));
            if (bad >= i8211_pkg::CHAR_ZERO) bad = bad + 8'd10;
            leader[spoil_at] = bad;
        end

        for (int i = 0; i < 24; i++) send_byte(leader[i]);
        foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
        repeat (gap_len) send_byte(8'($urandom_range(0, 255)));
        foreach (area_bytes[i]) send_byte(area_bytes[i]);
        dir_bytes.delete();
        area_bytes.delete();
    endtask

    // one record of random shape: mostly well formed, some broken on purpose
    task automatic add_random_record();
        int unsigned style;
        int unsigned tsz;
        int unsigned lsz;
        int unsigned psz;
        int unsigned r;
        int          base_ovr;
        int          gap_len;

        style = $urandom_range(0, 9);
        tsz = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        lsz = $urandom_range(0, 4);
        psz = $urandom_range(0, 4);
        if (style == 7) begin
            tsz = 0;
            lsz = 0;
            psz = 0;
        end else if (tsz + lsz + psz == 0) begin
            tsz = 1;
        end

        if (style == 8) begin
            // short leader, nothing after it
            ship_record(lsz, psz, tsz, 0, $urandom_range(0, 99999), $urandom_range(0, 24), -1);
        end else begin
            if (style == 7) begin
                // no subfields: stray directory bytes are dropped
                repeat ($urandom_range(0, 3))
                    dir_bytes.push_back(8'($urandom_range(8'h1F, 8'hFF)));
            end else begin
                repeat ($urandom_range(0, 3))
                    add_entry({$urandom, $urandom, 8'($urandom)}, tsz, $urandom, lsz,
                              $urandom, psz);
            end
            dir_bytes.push_back(i8211_pkg::FIELD_SEP);
            if (style == 9) dir_bytes[$urandom_range(0, dir_bytes.size() - 1)] =
                8'($urandom_range(0, 255));
            repeat ($urandom_range(0, 24)) begin
                r = $urandom_range(0, 9);
                area_bytes.push_back((r == 0) ? i8211_pkg::FIELD_SEP :
                                     (r == 1) ? i8211_pkg::UNIT_SEP :
                                     8'($urandom_range(0, 255)));
            end
            base_ovr = -1;
            gap_len  = $urandom_range(0, 3);
            if (style == 6) begin
                // base address inside the directory, or below the leader
                gap_len  = 0;
                base_ovr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) :
                           24 + $urandom_range(0, dir_bytes.size() - 1);
            end
            ship_record(lsz, psz, tsz, gap_len, base_ovr, -1, (style == 9) ? -2 : -1);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // leaders that end the record at once: length zero, exactly 24, below 24
    task automatic test_short_leaders();
        ship_record(0, 0, 0, 0, 0, 0, -1);
        ship_record(9, 9, 9, 0, 99999, 24, -1);
        ship_record(1, 1, 1, 0, 24, 23, -1);
    endtask

    task automatic test_directory_entries();
        // widest entries, all-ones tag, then a zero entry; separators in the area
        add_entry(72'hFFFFFFFF, 4, 999999999, 9, 999999999, 9);
        add_entry(72'("ABCD"), 4, 0, 9, 0, 9);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"x", i8211_pkg::UNIT_SEP, "y", i8211_pkg::FIELD_SEP, "z"};
        ship_record(9, 9, 4, 2, -1, -1, -1);

        // length only
        add_entry(72'h0, 0, 7, 1, 0, 0);
        add_entry(72'h0, 0, 3, 1, 0, 0);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"a", "b"};
        ship_record(1, 0, 0, 0, -1, -1, -1);

        // position only
        add_entry(72'h0, 0, 0, 0, 9, 1);
        add_entry(72'h0, 0, 0, 0, 0, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"c"};
        ship_record(0, 1, 0, 1, -1, -1, -1);

        // tag only
        add_entry(72'h00, 1, 0, 0, 0, 0);
        add_entry(72'h80, 1, 0, 0, 0, 0);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{8'h00, 8'hFF};
        ship_record(0, 0, 1, 0, -1, -1, -1);

        // empty directory, terminator is the final byte
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        ship_record(2, 2, 2, 0, -1, -1, -1);

        // empty directory, record ends inside the gap
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        ship_record(2, 2, 2, 3, -1, -1, -1);

        // terminator where the first entry would start, rest of directory dropped
        dir_bytes = '{i8211_pkg::FIELD_SEP, "Q", "1", "2"};
        area_bytes = '{"o", "k"};
        ship_record(1, 1, 2, 0, -1, -1, -1);

        // field separator inside a tag is just a tag character
        add_entry(72'({8'h41, i8211_pkg::FIELD_SEP}), 2, 5, 1, 6, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{i8211_pkg::UNIT_SEP, i8211_pkg::UNIT_SEP, i8211_pkg::FIELD_SEP, "q"};
        ship_record(1, 1, 2, 1, -1, -1, -1);
    endtask

    task automatic test_format_errors();
        // non-digit in an entry length
        dir_bytes = '{"A", "x", "5", i8211_pkg::FIELD_SEP};
        area_bytes = '{"d", i8211_pkg::UNIT_SEP, "e"};
        ship_record(1, 1, 1, 0, -1, -1, -1);

        // non-digit in the record length, then in the base address
        add_entry(72'("B"), 1, 2, 1, 3, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"f"};
        ship_record(1, 1, 1, 0, -1, -1, 0);
        add_entry(72'("C"), 1, 4, 1, 5, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"g"};
        ship_record(1, 1, 1, 0, -1, -1, 12);

        // non-digit as the length size character
        add_entry(72'("T"), 1, 0, 0, 4, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"h"};
        ship_record(0, 1, 1, 0, -1, -1, 20);

        // oversized tag keeps its last four characters
        add_entry(72'h01020304050607, 7, 42, 2, 17, 2);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"i", "j"};
        ship_record(2, 2, 7, 0, -1, -1, -1);

        // all subfield sizes zero
        dir_bytes = '{"j", "k", i8211_pkg::FIELD_SEP};
        area_bytes = '{"m", "n"};
        ship_record(0, 0, 0, 0, -1, -1, -1);

        // base address in the middle of the directory
        add_entry(72'("D"), 1, 1, 1, 2, 1);
        add_entry(72'("E"), 1, 3, 1, 4, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"p", "r"};
        ship_record(1, 1, 1, 0, 28, -1, -1);

        // base address below the leader
        add_entry(72'("F"), 1, 5, 1, 6, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes = '{"s"};
        ship_record(1, 1, 1, 0, 10, -1, -1);
    endtask

    // both counters run into their cap
    task automatic test_index_saturation();
        add_entry(72'("S"), 1, 1, 1, 1, 1);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        repeat (257) area_bytes.push_back(i8211_pkg::UNIT_SEP);
        repeat (257) area_bytes.push_back(i8211_pkg::FIELD_SEP);
        area_bytes.push_back("e");
        area_bytes.push_back("f");
        ship_record(1, 1, 1, 0, -1, -1, -1);
    endtask

    // random records; idling off in places and for the final stretch
    task automatic test_random_records();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < 120) begin
            idle_on = (bytes_sent - start < 80) && ($urandom_range(0, 3) != 0);
            add_random_record();
        end
        idle_on = 0;
    endtask

    // largest base address, record ends with the directory terminator
    task automatic test_longest_record();
        add_entry(72'("XYZW"), 4, 123456789, 9, 987654321, 9);
        dir_bytes.push_back(i8211_pkg::FIELD_SEP);
        ship_record(9, 9, 4, 0, 99999, -1, -1);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_on     = 1;
        error_count = 0;
        bytes_sent  = 0;
        clear_parser();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_short_leaders();
        test_directory_entries();
        test_format_errors();
        test_index_saturation();
        test_random_records();
        test_longest_record();
        s_tvalid <= 1'b0;

        // drain the expected words, then let the registered result settle before the verdict
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (expected_words.size() != 0)
                $error("%0d expected words never arrived", expected_words.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
